[design/jsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_pkg: shared types and constants
// Generator constants, rotation helper, sequencer states and the control
// bundle that the sequencer sends to the generator datapath.
// ----------------------------------------------------------------------------
package jsf_pkg;

  localparam int WORD_W = 64;
  localparam int CNT_W  = 4;

  localparam logic [WORD_W-1:0] GEN_INIT_A = 64'h0000_0000_f1ea_5eed;
  localparam logic [CNT_W-1:0]  FULL_COUNT = 4'd8;

  localparam int ROT_B = 7;
  localparam int ROT_C = 13;
  localparam int ROT_D = 37;

  localparam int WARMUP_ROUNDS_DEF = 20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WARM_E,
    ST_WARM_F,
    ST_KEY_E,
    ST_KEY_F,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic load;    // load a from GEN_INIT_A and b, c, d from the seed
    logic step_e;  // first half of a generator step
    logic step_f;  // second half of a generator step
    logic emit;    // commit the result item to the output register
  } gen_ctl_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int k);
    rotl = (v << k) | (v >> (WORD_W - k));
  endfunction

endpackage

[design/jsf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_if: channel interfaces
// Message word input, result output and seed write channels.
// ----------------------------------------------------------------------------
interface jsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [jsf_pkg::WORD_W-1:0]  data_word;
  logic [jsf_pkg::CNT_W-1:0]   byte_count;
  logic                        first_word;
  logic                        last_word;

  modport source (output valid, data_word, byte_count, first_word, last_word, input ready);
  modport sink   (input valid, data_word, byte_count, first_word, last_word, output ready);
endinterface

interface jsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [jsf_pkg::WORD_W-1:0]  out_word;
  logic [jsf_pkg::CNT_W-1:0]   out_count;
  logic                        out_last;

  modport source (output valid, out_word, out_count, out_last, input ready);
  modport sink   (input valid, out_word, out_count, out_last, output ready);
endinterface

interface jsf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [jsf_pkg::WORD_W-1:0]  seed_value;

  modport source (output valid, seed_value, input ready);
  modport sink   (input valid, seed_value, output ready);
endinterface

[design/jsf_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_gen: generator state and shared step unit
// Holds the four state words and runs one generator step in two halves.
// ----------------------------------------------------------------------------
module jsf_gen (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jsf_pkg::gen_ctl_t          ctl,
  input  logic [jsf_pkg::WORD_W-1:0] seed,
  output logic [jsf_pkg::WORD_W-1:0] gen_d
);

  logic [jsf_pkg::WORD_W-1:0] a_r, b_r, c_r, d_r, e_r;
  logic [jsf_pkg::WORD_W-1:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    d_nxt = d_r;
    e_nxt = e_r;
    if (ctl.load) begin
      a_nxt = jsf_pkg::GEN_INIT_A;
      b_nxt = seed;
      c_nxt = seed;
      d_nxt = seed;
    end else if (ctl.step_e) begin
      e_nxt = a_r - jsf_pkg::rotl(b_r, jsf_pkg::ROT_B);
      a_nxt = b_r ^ jsf_pkg::rotl(c_r, jsf_pkg::ROT_C);
      b_nxt = c_r + jsf_pkg::rotl(d_r, jsf_pkg::ROT_D);
    end else if (ctl.step_f) begin
      // a already holds the new value here
      c_nxt = d_r + e_r;
      d_nxt = e_r + a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
    end else begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt;
  end

  assign gen_d = d_r;

endmodule

[design/jsf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf_ctrl: sequencer
// Steps the generator through reseed and warm-up on a first item and the
// keystream step on a full item; each result goes to the output register.
// ----------------------------------------------------------------------------
module jsf_ctrl #(
  parameter int WARMUP_ROUNDS = jsf_pkg::WARMUP_ROUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic              in_first,
  input  logic              in_full,
  input  logic              out_free,
  output logic              idle,
  output jsf_pkg::gen_ctl_t ctl
);

  localparam int RW = (WARMUP_ROUNDS < 1) ? 1 : $clog2(WARMUP_ROUNDS + 1);

  jsf_pkg::seq_state_t state_r, state_nxt;
  logic [RW-1:0]       cnt_r, cnt_nxt;
  logic                full_r, full_nxt;
  logic                warm_done;

  assign warm_done = (cnt_r == RW'(WARMUP_ROUNDS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    full_nxt  = full_r;
    case (state_r)
      jsf_pkg::ST_IDLE: begin
        if (in_accept) begin
          full_nxt = in_full;
          if (in_first) begin
            state_nxt = jsf_pkg::ST_LOAD;
          end else if (in_full) begin
            state_nxt = jsf_pkg::ST_KEY_E;
          end else begin
            state_nxt = jsf_pkg::ST_EMIT;
          end
        end
      end
      jsf_pkg::ST_LOAD: begin
        cnt_nxt = '0;
        if (WARMUP_ROUNDS != 0) begin
          state_nxt = jsf_pkg::ST_WARM_E;
        end else if (full_r) begin
          state_nxt = jsf_pkg::ST_KEY_E;
        end else begin
          state_nxt = jsf_pkg::ST_EMIT;
        end
      end
      jsf_pkg::ST_WARM_E: state_nxt = jsf_pkg::ST_WARM_F;
      jsf_pkg::ST_WARM_F: begin
        cnt_nxt = cnt_r + RW'(1);
        if (!warm_done) begin
          state_nxt = jsf_pkg::ST_WARM_E;
        end else if (full_r) begin
          state_nxt = jsf_pkg::ST_KEY_E;
        end else begin
          state_nxt = jsf_pkg::ST_EMIT;
        end
      end
      jsf_pkg::ST_KEY_E: state_nxt = jsf_pkg::ST_KEY_F;
      jsf_pkg::ST_KEY_F: state_nxt = jsf_pkg::ST_EMIT;
      jsf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = jsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = jsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idle       = 1'b0;
    ctl.load   = 1'b0;
    ctl.step_e = 1'b0;
    ctl.step_f = 1'b0;
    ctl.emit   = 1'b0;
    case (state_r)
      jsf_pkg::ST_IDLE:   idle = 1'b1;
      jsf_pkg::ST_LOAD:   ctl.load = 1'b1;
      jsf_pkg::ST_WARM_E: ctl.step_e = 1'b1;
      jsf_pkg::ST_WARM_F: ctl.step_f = 1'b1;
      jsf_pkg::ST_KEY_E:  ctl.step_e = 1'b1;
      jsf_pkg::ST_KEY_F:  ctl.step_f = 1'b1;
      jsf_pkg::ST_EMIT:   ctl.emit = out_free;
      default:            idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jsf_pkg::ST_IDLE;
      cnt_r   <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      full_r  <= full_nxt;
    end
  end

  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step_f |-> $past(ctl.step_e))
    else $error("second step half without first half");

  a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> $past(state_r) == jsf_pkg::ST_IDLE)
    else $error("reseed outside message start");

  a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jsf_pkg::ST_WARM_E || state_r == jsf_pkg::ST_WARM_F)
      |-> cnt_r < RW'(WARMUP_ROUNDS))
    else $error("warm-up count overrun");

endmodule

[design/jsf64_keystream_xor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsf64_keystream_xor: keystream XOR cipher on the 64-bit small fast generator
// Full 8-byte words are XORed with the generator output; shorter words pass
// through. A first_word item reseeds and warms up the generator.
// ----------------------------------------------------------------------------
// One item at a time. A generator step runs in two halves on one shared step
// unit: a full word passes KEY_E, KEY_F and EMIT, a partial word only EMIT;
// a first_word item passes LOAD and WARMUP_ROUNDS warm-up rounds (default
// of 20) first, for reseed and warm-up. The result sits in an output
// register, so the next item is taken while it waits to drain. The user is
// to write the seed register through cfg_ch at an idle time only; the block
// itself does not enforce this. The seed is used at the next first_word.
module jsf64_keystream_xor #(
  parameter int WARMUP_ROUNDS = jsf_pkg::WARMUP_ROUNDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  jsf_in_if.sink     in_ch,
  jsf_out_if.source  out_ch,
  jsf_cfg_if.sink    cfg_ch
);

  jsf_pkg::gen_ctl_t ctl;
  logic              idle;
  logic              in_accept;
  logic              out_free;

  logic [jsf_pkg::WORD_W-1:0] seed_r;
  logic [jsf_pkg::WORD_W-1:0] gen_d;
  logic [jsf_pkg::WORD_W-1:0] word_r;
  logic [jsf_pkg::CNT_W-1:0]  count_r;
  logic                       last_r;

  logic                       out_valid_r;
  logic [jsf_pkg::WORD_W-1:0] out_word_r;
  logic [jsf_pkg::CNT_W-1:0]  out_count_r;
  logic                       out_last_r;

  assign in_ch.ready  = idle;
  assign in_accept    = in_ch.valid & idle;
  assign out_free     = ~out_valid_r | out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_ch.valid) begin
      seed_r <= cfg_ch.seed_value;
    end
  end

  // hold the item while the sequencer works on it
  always_ff @(posedge clk) begin
    if (in_accept) begin
      word_r  <= in_ch.data_word;
      count_r <= in_ch.byte_count;
      last_r  <= in_ch.last_word;
    end
  end

  jsf_ctrl #(
    .WARMUP_ROUNDS (WARMUP_ROUNDS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_first  (in_ch.first_word),
    .in_full   (in_ch.byte_count == jsf_pkg::FULL_COUNT),
    .out_free  (out_free),
    .idle      (idle),
    .ctl       (ctl)
  );

  jsf_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .seed  (seed_r),
    .gen_d (gen_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // d holds the fresh keystream word after a full-word step
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_word_r  <= (count_r == jsf_pkg::FULL_COUNT) ? (word_r ^ gen_d) : word_r;
      out_count_r <= count_r;
      out_last_r  <= last_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_word  = out_word_r;
  assign out_ch.out_count = out_count_r;
  assign out_ch.out_last  = out_last_r;

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.emit))
    else $error("result item without commit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> !in_accept)
    else $error("item taken while result pending in sequencer");

endmodule
